// ===== rtl/chr_pkg.sv =====
`default_nettype none
package chr_pkg;

  // Ring geometry and item field widths.
  localparam int RING_SLOTS   = 256;
  localparam int SLOT_W       = 8;
  localparam int MACH_W       = 4;
  localparam int MAX_MACHINES = 16;
  localparam int MAX_SHARDS   = 16;
  localparam int CNT_W        = 5;
  localparam int FILL_W       = 9;
  localparam int LFSR_W       = 32;

  // Occupancy is scanned one chunk of slots per cycle.
  localparam int CHUNK_W    = 16;
  localparam int NUM_CHUNKS = RING_SLOTS / CHUNK_W;
  localparam int CHUNK_IW   = 4;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  // Operation codes.
  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_SHARDS = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_REL_RD = 13'b0000000000010,
    S_REL_WR = 13'b0000000000100,
    S_DRAW   = 13'b0000000001000,
    S_POP    = 13'b0000000010000,
    S_MOD    = 13'b0000000100000,
    S_PRD1   = 13'b0000001000000,
    S_PRD2   = 13'b0000010000000,
    S_PWR    = 13'b0000100000000,
    S_ASSIGN = 13'b0001000000000,
    S_SCAN   = 13'b0010000000000,
    S_LKOWN  = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/chr_ram.sv =====
`default_nettype none
module chr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/chr_mod_unit.sv =====
`default_nettype none
module chr_mod_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [chr_pkg::LFSR_W-1:0]   dividend,
  input  wire  [chr_pkg::FILL_W-1:0]   divisor,
  output logic                         done,
  output logic [chr_pkg::SLOT_W-1:0]   remainder
);
  import chr_pkg::*;

  localparam int STEPS = 4;
  localparam int ITERS = LFSR_W / STEPS;

  logic                  busy_r;
  logic [2:0]            iter_r;
  logic [LFSR_W-1:0]     num_r, num_nxt;
  logic [FILL_W-1:0]     rem_r, rem_nxt;
  logic [FILL_W-1:0]     div_r;
  logic                  done_r;

  // Four restoring remainder steps per cycle, most significant bits first.
  always_comb begin
    logic [FILL_W:0] t;
    rem_nxt = rem_r;
    num_nxt = num_r;
    for (int j = 0; j < STEPS; j++) begin
      t = {rem_nxt, num_nxt[LFSR_W-1]};
      num_nxt = {num_nxt[LFSR_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 3'd1;
        if (iter_r == 3'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[SLOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/consistent_hash_ring_shard_map.sv =====
// Channel  | Direction | Beat contents
// ---------+-----------+---------------------------------------------------
// in_      | input     | func, mach_id, hash_code
// out_     | output    | status, owner_id, shard_slot, last
// APB      | config    | reg 0 shards_per_machine, reg 1 random_seed
//
// One item is worked on at a time; the next is taken once its last beat is loaded
// into the output register. An add with room first releases any slots the machine already holds,
// then takes each slot from the freed stack or, when that is empty, draws a fresh one
// through the modulo unit. A remove releases the slots and then emits. A lookup walks
// the ring with the 16-slot-per-cycle occupancy scan.
// Reset is synchronous; occupancy and permutation valid bits clear at once.
// A stalled result beat holds the sequencer only when it has the next beat to load.
`default_nettype none
module consistent_hash_ring_shard_map (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   in_func,
  input  wire  [chr_pkg::MACH_W-1:0]   in_mach_id,
  input  wire  [chr_pkg::SLOT_W-1:0]   in_hash_code,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [chr_pkg::MACH_W-1:0]   out_owner_id,
  output logic [chr_pkg::SLOT_W-1:0]   out_shard_slot,
  output logic                         out_last,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [2:0]                   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import chr_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]      shards_r;
  logic [LFSR_W-1:0]     seed_r;
  logic [LFSR_W-1:0]     lfsr_r;
  logic [FILL_W-1:0]     fresh_r, freed_top_r, in_use_r;
  logic [CNT_W-1:0]      cnt_r [MAX_MACHINES];
  logic [RING_SLOTS-1:0] occ_r, pvalid_r;

  logic [1:0]            func_r;
  logic [MACH_W-1:0]     mach_r;
  logic [SLOT_W-1:0]     hash_r;
  logic [CNT_W-1:0]      k_r, n_r, idx_r;
  logic [SLOT_W-1:0]     ri_r, val_r, slot_r;
  logic [CHUNK_IW-1:0]   chunk_r;
  logic [CHUNK_IW:0]     step_r;
  logic [1:0]            res_status_r;
  logic [MACH_W-1:0]     res_owner_r;
  logic [SLOT_W-1:0]     res_slot_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [MACH_W-1:0]     out_owner_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_last_r;

  // Memory ports.
  logic                  own_we, own_re;
  logic [SLOT_W-1:0]     own_waddr, own_raddr;
  logic [MACH_W-1:0]     own_rdata;
  logic                  perm_we, perm_re;
  logic [SLOT_W-1:0]     perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic                  freed_we, freed_re;
  logic [SLOT_W-1:0]     freed_waddr, freed_raddr, freed_rdata;
  logic                  list_we, list_re;
  logic [SLOT_W-1:0]     list_waddr, list_raddr, list_rdata;

  logic                  mod_start, mod_done;
  logic [SLOT_W-1:0]     mod_rem;

  chr_ram #(.WIDTH(MACH_W), .DEPTH(RING_SLOTS)) u_owner_ram (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(mach_r),
    .re(own_re), .raddr(own_raddr), .rdata(own_rdata)
  );

  chr_ram #(.WIDTH(SLOT_W), .DEPTH(RING_SLOTS)) u_perm_ram (
    .clk(clk), .we(perm_we), .waddr(perm_waddr), .wdata(perm_wdata),
    .re(perm_re), .raddr(perm_raddr), .rdata(perm_rdata)
  );

  chr_ram #(.WIDTH(SLOT_W), .DEPTH(RING_SLOTS)) u_freed_ram (
    .clk(clk), .we(freed_we), .waddr(freed_waddr), .wdata(list_rdata),
    .re(freed_re), .raddr(freed_raddr), .rdata(freed_rdata)
  );

  chr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_MACHINES * MAX_SHARDS)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(slot_r),
    .re(list_re), .raddr(list_raddr), .rdata(list_rdata)
  );

  logic [LFSR_W-1:0] lfsr_step;
  assign lfsr_step = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  chr_mod_unit u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(lfsr_step),
    .divisor(fresh_r), .done(mod_done), .remainder(mod_rem)
  );

  // Configuration port.
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_SHARDS: prdata = {{(32-CNT_W){1'b0}}, shards_r};
      REG_SEED:   prdata = seed_r;
      default:    prdata = '0;
    endcase
  end

  // Combinational helpers.
  logic              out_free;
  logic              out_valid_nxt;
  logic [CNT_W-1:0]  k_sat;
  logic [FILL_W:0]   need;
  logic [SLOT_W-1:0] fc_m1;
  logic [CHUNK_W-1:0] chunk_bits, chunk_mask, hits;
  logic [CHUNK_IW-1:0] hit_idx;
  logic              slot_last;

  assign out_free  = !out_valid_r || out_ready;
  assign fc_m1     = 8'(fresh_r - 9'd1);
  assign slot_last = (idx_r + 5'd1) == k_r;

  // A result beat leaves on ready; a new one loads from the assign or emit state whenever the register is free.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (((state_r == S_ASSIGN) || (state_r == S_EMIT)) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    if (shards_r == '0) begin
      k_sat = 5'd1;
    end else if (shards_r > CNT_W'(MAX_SHARDS)) begin
      k_sat = CNT_W'(MAX_SHARDS);
    end else begin
      k_sat = shards_r;
    end
    need = {1'b0, in_use_r} - {5'd0, cnt_r[in_mach_id]} + {5'd0, k_sat};
  end

  // Occupancy chunk under scan: the part at or after the hash first, the part before it on the final wrap.
  always_comb begin
    chunk_bits = occ_r[chunk_r * CHUNK_W +: CHUNK_W];
    if (step_r == '0) begin
      chunk_mask = {CHUNK_W{1'b1}} << hash_r[CHUNK_IW-1:0];
    end else if (step_r == (CHUNK_IW+1)'(NUM_CHUNKS)) begin
      chunk_mask = ~({CHUNK_W{1'b1}} << hash_r[CHUNK_IW-1:0]);
    end else begin
      chunk_mask = {CHUNK_W{1'b1}};
    end
    hits = chunk_bits & chunk_mask;
    hit_idx = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      if (hits[b]) begin
        hit_idx = CHUNK_IW'(b);
      end
    end
  end

  // Sequencer and memory port control.
  always_comb begin
    state_nxt   = state_r;
    own_we      = 1'b0;
    own_re      = 1'b0;
    own_waddr   = slot_r;
    own_raddr   = {chunk_r, hit_idx};
    perm_we     = 1'b0;
    perm_re     = 1'b0;
    perm_waddr  = ri_r;
    perm_wdata  = pvalid_r[fc_m1] ? perm_rdata : fc_m1;
    perm_raddr  = ri_r;
    freed_we    = 1'b0;
    freed_re    = 1'b0;
    freed_waddr = freed_top_r[SLOT_W-1:0];
    freed_raddr = 8'(freed_top_r - 9'd1);
    list_we     = 1'b0;
    list_re     = 1'b0;
    list_waddr  = {mach_r, idx_r[MACH_W-1:0]};
    list_raddr  = {mach_r, idx_r[MACH_W-1:0]};
    mod_start   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_ADD: begin
              if (need > (FILL_W+1)'(RING_SLOTS)) state_nxt = S_EMIT;
              else if (cnt_r[in_mach_id] != '0) state_nxt = S_REL_RD;
              else state_nxt = S_DRAW;
            end
            FN_REMOVE: begin
              if (cnt_r[in_mach_id] == '0) state_nxt = S_EMIT;
              else state_nxt = S_REL_RD;
            end
            FN_LOOKUP: state_nxt = S_SCAN;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_REL_RD: begin
        list_re   = 1'b1;
        state_nxt = S_REL_WR;
      end
      S_REL_WR: begin
        freed_we = freed_top_r < FILL_W'(RING_SLOTS);
        if ((idx_r + 5'd1) == n_r) begin
          state_nxt = (func_r == FN_ADD) ? S_DRAW : S_EMIT;
        end else begin
          state_nxt = S_REL_RD;
        end
      end
      S_DRAW: begin
        if (freed_top_r != '0) begin
          freed_re  = 1'b1;
          state_nxt = S_POP;
        end else begin
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_POP: state_nxt = S_ASSIGN;
      S_MOD: begin
        if (mod_done) state_nxt = S_PRD1;
      end
      S_PRD1: begin
        perm_re   = 1'b1;
        state_nxt = S_PRD2;
      end
      S_PRD2: begin
        perm_re    = 1'b1;
        perm_raddr = fc_m1;
        state_nxt  = S_PWR;
      end
      S_PWR: begin
        perm_we   = 1'b1;
        state_nxt = S_ASSIGN;
      end
      S_ASSIGN: begin
        if (out_free) begin
          own_we    = 1'b1;
          list_we   = 1'b1;
          state_nxt = slot_last ? S_IDLE : S_DRAW;
        end
      end
      S_SCAN: begin
        if (hits != '0) begin
          own_re    = 1'b1;
          state_nxt = S_LKOWN;
        end else if (step_r == (CHUNK_IW+1)'(NUM_CHUNKS)) begin
          state_nxt = S_EMIT;
        end
      end
      S_LKOWN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shards_r    <= 5'd3;
      seed_r      <= 32'd1;
      lfsr_r      <= 32'd1;
      fresh_r     <= FILL_W'(RING_SLOTS);
      freed_top_r <= '0;
      in_use_r    <= '0;
      occ_r       <= '0;
      pvalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_MACHINES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_wr) begin
        if (paddr[2] == REG_SHARDS) begin
          shards_r <= pwdata[CNT_W-1:0];
        end else begin
          seed_r <= pwdata;
          lfsr_r <= (pwdata == '0) ? 32'd1 : pwdata;
        end
      end

      unique case (state_r)
        S_REL_WR: begin
          if (freed_top_r < FILL_W'(RING_SLOTS)) freed_top_r <= freed_top_r + 9'd1;
          occ_r[list_rdata] <= 1'b0;
          if (in_use_r != '0) in_use_r <= in_use_r - 9'd1;
          if ((idx_r + 5'd1) == n_r) cnt_r[mach_r] <= '0;
        end
        S_DRAW: begin
          if (freed_top_r != '0) freed_top_r <= freed_top_r - 9'd1;
          else lfsr_r <= lfsr_step;
        end
        S_PWR: begin
          pvalid_r[ri_r] <= 1'b1;
          fresh_r        <= fresh_r - 9'd1;
        end
        S_ASSIGN: begin
          if (out_free) begin
            occ_r[slot_r] <= 1'b1;
            in_use_r      <= in_use_r + 9'd1;
            if (slot_last) cnt_r[mach_r] <= k_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item context, working values and the result beat.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        func_r       <= in_func;
        mach_r       <= in_mach_id;
        hash_r       <= in_hash_code;
        k_r          <= k_sat;
        n_r          <= cnt_r[in_mach_id];
        idx_r        <= '0;
        chunk_r      <= in_hash_code[SLOT_W-1:CHUNK_IW];
        step_r       <= '0;
        res_owner_r  <= in_mach_id;
        res_slot_r   <= '0;
        if (in_func == FN_ADD) res_status_r <= ST_NO_ROOM;
        else res_status_r <= (cnt_r[in_mach_id] == '0) ? ST_UNKNOWN : ST_OK;
      end
      S_REL_WR: begin
        idx_r <= ((idx_r + 5'd1) == n_r) ? '0 : idx_r + 5'd1;
      end
      S_POP:  slot_r <= freed_rdata;
      S_MOD:  ri_r <= mod_rem;
      S_PRD2: val_r <= pvalid_r[ri_r] ? perm_rdata : ri_r;
      S_PWR:  slot_r <= val_r;
      S_ASSIGN: begin
        if (out_free) begin
          out_status_r <= ST_OK;
          out_owner_r  <= mach_r;
          out_slot_r   <= slot_r;
          out_last_r   <= slot_last;
          idx_r        <= idx_r + 5'd1;
        end
      end
      S_SCAN: begin
        if (hits != '0) begin
          res_slot_r <= {chunk_r, hit_idx};
        end else begin
          chunk_r      <= chunk_r + 4'd1;
          step_r       <= step_r + 5'd1;
          res_status_r <= ST_EMPTY;
          res_owner_r  <= '0;
        end
      end
      S_LKOWN: begin
        res_status_r <= ST_OK;
        res_owner_r  <= own_rdata;
      end
      S_EMIT: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_owner_r  <= res_owner_r;
          out_slot_r   <= res_slot_r;
          out_last_r   <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_owner_id   = out_owner_r;
  assign out_shard_slot = out_slot_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire
